// ===== sv/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasteriser package
// Shared constants: default coordinate width, queue depth and item kinds.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

endpackage

// ===== sv/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasteriser
// All-octant midpoint line stepper with a decoupled command front end.
//
//   Channel   Direction  tdata (low bit first)              tuser  tlast
//   s_axis    in         start_x, start_y, end_x, end_y      kind   -
//   m_axis    out        pixel_x, pixel_y                    -      last
//
// A transfer on s_axis enters a two-entry command queue in the same cycle.
// The stepper takes one command per clock while its output register is free
// or being read, so a pixel leaves every clock when m_axis_tready stays high
// and commands are queued; the queue buffers commands while the output stalls.
// Reset empties the queue and clears the line state and the output valid flag.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import mlr_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int CMD_W  = 4*C + 3;
  localparam int OUT_W  = ((2*C+7)/8)*8;

  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_head;
  logic             q_full;
  logic             q_empty;
  logic             cmd_pop;
  logic [C-1:0]     pixel_x;
  logic [C-1:0]     pixel_y;

  assign s_axis_tready = !q_full;

  mlr_front #(.COORD_BITS(C)) u_front (
    .kind    (s_axis_tuser),
    .start_x (s_axis_tdata[C-1:0]),
    .start_y (s_axis_tdata[2*C-1:C]),
    .end_x   (s_axis_tdata[3*C-1:2*C]),
    .end_y   (s_axis_tdata[4*C-1:3*C]),
    .cmd     (cmd_in)
  );

  mlr_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH_DEF)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_data (cmd_in),
    .full      (q_full),
    .pop       (cmd_pop),
    .empty     (q_empty),
    .head      (cmd_head)
  );

  mlr_back #(.COORD_BITS(C)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

// ===== sv/mlr_front.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasteriser front end
// Classifies input items and works out the axis deltas and step directions
// of a start item before it enters the command queue.
// ----------------------------------------------------------------------------
module mlr_front #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                    kind,
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic [4*COORD_BITS+2:0] cmd
);
  import mlr_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        adx;
  logic [COORD_BITS:0]        ady;
  logic                       x_neg;
  logic                       y_neg;

  always_comb begin
    dx    = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
    dy    = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
    x_neg = dx[COORD_BITS];
    y_neg = dy[COORD_BITS];
    adx   = x_neg ? (~dx + 1'b1) : dx;
    ady   = y_neg ? (~dy + 1'b1) : dy;
    if (kind == KIND_START) begin
      cmd = {y_neg, x_neg, ady[COORD_BITS-1:0], adx[COORD_BITS-1:0], start_y, start_x, KIND_START};
    end else begin
      cmd = {{(4*COORD_BITS+2){1'b0}}, KIND_ADVANCE};
    end
  end

endmodule

// ===== sv/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasteriser command queue
// Small first-in first-out buffer between the front end and the stepper.
// ----------------------------------------------------------------------------
module mlr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mlr_back.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasteriser stepper
// Sets up the decision value from a start command and takes one midpoint
// step per advance command, holding the pixel in an output register.
// ----------------------------------------------------------------------------
module mlr_back #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  logic [4*COORD_BITS+2:0] cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic                    last
);
  import mlr_pkg::*;

  localparam int C = COORD_BITS;

  logic               busy;
  logic [C-1:0]       cur_x;
  logic [C-1:0]       cur_y;
  logic [C-1:0]       steps_left;
  logic [C+2:0]       decision;
  logic [C+1:0]       inc_straight;
  logic [C+1:0]       inc_diagonal;
  logic               x_major;
  logic               x_neg;
  logic               y_neg;

  logic               c_kind;
  logic [C-1:0]       c_x0;
  logic [C-1:0]       c_y0;
  logic [C-1:0]       c_adx;
  logic [C-1:0]       c_ady;
  logic               c_xneg;
  logic               c_yneg;

  logic               s_xmaj;
  logic [C-1:0]       s_major;
  logic [C-1:0]       s_minor;
  logic               dec_pos;
  logic               step_x;
  logic               step_y;
  logic [C-1:0]       x_delta;
  logic [C-1:0]       y_delta;
  logic [C-1:0]       nx;
  logic [C-1:0]       ny;
  logic [C-1:0]       steps_next;

  assign {c_yneg, c_xneg, c_ady, c_adx, c_y0, c_x0, c_kind} = cmd;
  assign cmd_pop = cmd_valid && (!out_valid || out_ready);

  always_comb begin
    s_xmaj     = (c_adx >= c_ady);
    s_major    = s_xmaj ? c_adx : c_ady;
    s_minor    = s_xmaj ? c_ady : c_adx;
    dec_pos    = !decision[C+2] && (decision != '0);
    step_x     = x_major || dec_pos;
    step_y     = !x_major || dec_pos;
    x_delta    = x_neg ? '1 : C'(1);
    y_delta    = y_neg ? '1 : C'(1);
    nx         = step_x ? cur_x + x_delta : cur_x;
    ny         = step_y ? cur_y + y_delta : cur_y;
    steps_next = steps_left - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      steps_left   <= '0;
      decision     <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      x_major      <= 1'b0;
      x_neg        <= 1'b0;
      y_neg        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd_pop && (c_kind == KIND_START || busy)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop) begin
        if (c_kind == KIND_START) begin
          x_major      <= s_xmaj;
          x_neg        <= c_xneg;
          y_neg        <= c_yneg;
          decision     <= {2'b00, s_minor, 1'b0} - {3'b000, s_major};
          inc_straight <= {1'b0, s_minor, 1'b0};
          inc_diagonal <= {1'b0, s_minor, 1'b0} - {1'b0, s_major, 1'b0};
          steps_left   <= s_major;
          cur_x        <= c_x0;
          cur_y        <= c_y0;
          busy         <= (s_major != '0);
          pixel_x      <= c_x0;
          pixel_y      <= c_y0;
          last         <= (s_major == '0);
        end else if (busy) begin
          if (dec_pos) begin
            decision <= decision + {inc_diagonal[C+1], inc_diagonal};
          end else begin
            decision <= decision + {inc_straight[C+1], inc_straight};
          end
          cur_x      <= nx;
          cur_y      <= ny;
          steps_left <= steps_next;
          busy       <= (steps_next != '0);
          pixel_x    <= nx;
          pixel_y    <= ny;
          last       <= (steps_next == '0);
        end
      end
    end
  end

endmodule
